// File: design/qvr_pkg.sv
package qvr_pkg;

    // field widths
    localparam int QW    = 18;  // quaternion component, Q2.16
    localparam int VW    = 32;  // vector component, Q16.16
    localparam int FRAC  = 16;  // fraction bits dropped by each rounding step

    // first product stage: q * (0, v)
    localparam int M1_W  = QW + VW;        // one product
    localparam int S1_W  = M1_W + 1;       // sum of three products
    localparam int P_W   = S1_W - FRAC;    // rounded component of p

    // second product stage: p * conj(q)
    localparam int M2_W  = P_W + QW;       // one product
    localparam int S2_W  = M2_W + 2;       // sum of four products
    localparam int R_W   = S2_W - FRAC;    // rounded result before clamping

    localparam int N_PROD = 12;            // products per stage
    localparam int N_P    = 4;             // components of p
    localparam int N_OUT  = 3;             // vector components

    localparam int TDATA_W = N_OUT * VW;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [S1_W-1:0] RND1 = S1_W'(32768);
    localparam logic signed [S2_W-1:0] RND2 = S2_W'(32768);

    localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    localparam logic [QW-1:0] ROT_W_RESET = QW'(65536);  // 1.0

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_W = 2'd0,
        REG_ROT_X = 2'd1,
        REG_ROT_Y = 2'd2,
        REG_ROT_Z = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [QW-1:0] w;
        logic [QW-1:0] x;
        logic [QW-1:0] y;
        logic [QW-1:0] z;
    } t_quat;

    typedef struct packed {
        logic             valid;
        t_reg_idx         index;
        logic [QW-1:0]    data;
    } t_cfg_wr;

endpackage

// File: design/quaternion_vector_rotate_top.sv
// Rotates a stream of Q16.16 vectors by the quaternion q held in the four
// Q2.16 rotation registers, returning the vector part of q * (0, v) * conj(q).
// q is not normalised, so a quaternion of norm n also scales by n squared;
// the reset value is the identity. Each stage of products is rounded half up
// to 16 fraction bits, and a result outside the 32-bit range is clamped with
// the clipped flag (tuser) set. The datapath is four register stages: first
// products (12 multipliers, 18x32), sums giving p, second products
// (12 multipliers, 35x18), then sums, rounding and clamping into the output
// register. One vector is taken every cycle while o_s_tready is high, and
// each stage holds its item under back-pressure and bubbles close up, so a
// stalled output still lets three more vectors in. Write the rotation
// registers only while the pipeline is empty; the config port is always ready
// and takes effect the next cycle.
module quaternion_vector_rotate_top
    import qvr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // input vectors: in_x [31:0], in_y [63:32], in_z [95:64]
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [TDATA_W-1:0]   i_s_tdata,

    // results: out_x [31:0], out_y [63:32], out_z [95:64]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [TDATA_W-1:0]   o_m_tdata,
    // clipped [0]
    output logic                 o_m_tuser,

    // rotation register writes: 0 rot_w, 1 rot_x, 2 rot_y, 3 rot_z
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [QW-1:0]        i_cfg_data
);

    // configuration
    t_cfg_wr w_cfg_wr;
    t_quat   w_quat;

    assign o_cfg_ready     = 1'b1;
    assign w_cfg_wr.valid  = i_cfg_valid;
    assign w_cfg_wr.index  = t_reg_idx'(i_cfg_index);
    assign w_cfg_wr.data   = i_cfg_data;

    qvr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_cfg_wr),
        .o_quat  (w_quat)
    );

    logic signed [QW-1:0] w_qw, w_qx, w_qy, w_qz;
    assign w_qw = w_quat.w;
    assign w_qx = w_quat.x;
    assign w_qy = w_quat.y;
    assign w_qz = w_quat.z;

    // stage handshake: a stage loads when empty or when its successor loads
    logic [3:0] r_vld;
    logic [3:0] w_rdy;

    assign w_rdy[3] = !r_vld[3] || i_m_tready;
    assign w_rdy[2] = !r_vld[2] || w_rdy[3];
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];

    assign o_s_tready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= i_s_tvalid;
            if (w_rdy[1]) r_vld[1] <= r_vld[0];
            if (w_rdy[2]) r_vld[2] <= r_vld[1];
            if (w_rdy[3]) r_vld[3] <= r_vld[2];
        end
    end

    // stage 0: products of q and v
    logic signed [VW-1:0]   w_vx, w_vy, w_vz;
    logic signed [M1_W-1:0] n_m1 [N_PROD];
    logic signed [M1_W-1:0] r_m1 [N_PROD];

    assign w_vx = i_s_tdata[VW-1:0];
    assign w_vy = i_s_tdata[2*VW-1:VW];
    assign w_vz = i_s_tdata[3*VW-1:2*VW];

    always_comb begin
        // scalar part
        n_m1[0]  = w_qx * w_vx;
        n_m1[1]  = w_qy * w_vy;
        n_m1[2]  = w_qz * w_vz;
        // i part
        n_m1[3]  = w_qw * w_vx;
        n_m1[4]  = w_qy * w_vz;
        n_m1[5]  = w_qz * w_vy;
        // j part
        n_m1[6]  = w_qw * w_vy;
        n_m1[7]  = w_qz * w_vx;
        n_m1[8]  = w_qx * w_vz;
        // k part
        n_m1[9]  = w_qw * w_vz;
        n_m1[10] = w_qx * w_vy;
        n_m1[11] = w_qy * w_vx;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) r_m1 <= n_m1;
    end

    // stage 1: p = q * (0, v), rounded half up to 16 fraction bits
    logic signed [S1_W-1:0] w_s1 [N_P];
    logic signed [S1_W-1:0] w_t1 [N_P];
    logic signed [P_W-1:0]  n_p  [N_P];
    logic signed [P_W-1:0]  r_p  [N_P];

    always_comb begin
        w_s1[0] = -S1_W'(r_m1[0]) - S1_W'(r_m1[1]) - S1_W'(r_m1[2]);
        w_s1[1] =  S1_W'(r_m1[3]) + S1_W'(r_m1[4]) - S1_W'(r_m1[5]);
        w_s1[2] =  S1_W'(r_m1[6]) + S1_W'(r_m1[7]) - S1_W'(r_m1[8]);
        w_s1[3] =  S1_W'(r_m1[9]) + S1_W'(r_m1[10]) - S1_W'(r_m1[11]);
        for (int k = 0; k < N_P; k++) begin
            w_t1[k] = w_s1[k] + RND1;
            n_p[k]  = w_t1[k][S1_W-1:FRAC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) r_p <= n_p;
    end

    // stage 2: products of p and conj(q); index 0 is pw, then px, py, pz
    logic signed [M2_W-1:0] n_m2 [N_PROD];
    logic signed [M2_W-1:0] r_m2 [N_PROD];

    always_comb begin
        // x
        n_m2[0]  = r_p[1] * w_qw;
        n_m2[1]  = r_p[0] * w_qx;
        n_m2[2]  = r_p[2] * w_qz;
        n_m2[3]  = r_p[3] * w_qy;
        // y
        n_m2[4]  = r_p[2] * w_qw;
        n_m2[5]  = r_p[0] * w_qy;
        n_m2[6]  = r_p[3] * w_qx;
        n_m2[7]  = r_p[1] * w_qz;
        // z
        n_m2[8]  = r_p[3] * w_qw;
        n_m2[9]  = r_p[0] * w_qz;
        n_m2[10] = r_p[1] * w_qy;
        n_m2[11] = r_p[2] * w_qx;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) r_m2 <= n_m2;
    end

    // stage 3: sums, rounding and clamping into the output register
    logic signed [S2_W-1:0] w_s2  [N_OUT];
    logic signed [S2_W-1:0] w_t2  [N_OUT];
    logic        [R_W-1:0]  w_res [N_OUT];
    logic        [VW-1:0]   n_out [N_OUT];
    logic        [N_OUT-1:0] w_ovf;
    logic        [VW-1:0]   r_out [N_OUT];
    logic                   r_clip;

    always_comb begin
        for (int k = 0; k < N_OUT; k++) begin
            w_s2[k] = S2_W'(r_m2[4*k])   - S2_W'(r_m2[4*k+1])
                    - S2_W'(r_m2[4*k+2]) + S2_W'(r_m2[4*k+3]);
            w_t2[k]  = w_s2[k] + RND2;
            w_res[k] = w_t2[k][S2_W-1:FRAC];
            // out of range unless every bit above the sign matches it
            w_ovf[k] = w_res[k][R_W-1:VW-1] != {(R_W-VW+1){w_res[k][VW-1]}};
            if (w_ovf[k]) begin
                n_out[k] = w_res[k][R_W-1] ? VMIN : VMAX;
            end else begin
                n_out[k] = w_res[k][VW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_out  <= n_out;
            r_clip <= |w_ovf;
        end
    end

    assign o_m_tvalid = r_vld[3];
    assign o_m_tdata  = {r_out[2], r_out[1], r_out[0]};
    assign o_m_tuser  = r_clip;

endmodule

// File: design/qvr_cfg.sv
module qvr_cfg
    import qvr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_wr,
    output t_quat   o_quat
);

    t_quat r_quat;
    t_quat n_quat;

    always_comb begin
        n_quat = r_quat;
        if (i_wr.valid) begin
            unique case (i_wr.index)
                REG_ROT_W: n_quat.w = i_wr.data;
                REG_ROT_X: n_quat.x = i_wr.data;
                REG_ROT_Y: n_quat.y = i_wr.data;
                REG_ROT_Z: n_quat.z = i_wr.data;
                default:   n_quat = r_quat;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.w <= ROT_W_RESET;
            r_quat.x <= '0;
            r_quat.y <= '0;
            r_quat.z <= '0;
        end else begin
            r_quat <= n_quat;
        end
    end

    assign o_quat = r_quat;

endmodule

// File: design/qvr_checker.sv
module qvr_checker
    import qvr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 o_s_tready,
    input  logic [TDATA_W-1:0]   i_s_tdata,
    input  logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [TDATA_W-1:0]   o_m_tdata,
    input  logic                 o_m_tuser,
    input  logic                 i_cfg_valid,
    input  logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [QW-1:0]        i_cfg_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // an empty output register never blocks the input side
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // clipped flag only with a component at a range limit
    a_clip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            o_m_tdata[VW-1:0] == VMAX || o_m_tdata[VW-1:0] == VMIN ||
            o_m_tdata[2*VW-1:VW] == VMAX || o_m_tdata[2*VW-1:VW] == VMIN ||
            o_m_tdata[3*VW-1:2*VW] == VMAX || o_m_tdata[3*VW-1:2*VW] == VMIN)
        else $error("clipped set without a clamped component");

    // pipeline is empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result present after reset");

endmodule

bind quaternion_vector_rotate_top qvr_checker u_qvr_checker (.*);
